### rtl/core/page_frame_free_list_allocator_assert.svh
// Assertion macros for the page-frame allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PFFLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pffla check failed");

// next-cycle implication
`define PFFLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pffla check failed");

`endif

### rtl/core/pffla_pkg.sv
// Shared types and constants for the page-frame free-list allocator.
// No dependencies.
package pffla_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned FC_W   = 13;
  localparam int unsigned FLAG_W = 3;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;
  localparam logic [1:0] STATUS_NOTALLOC = 2'd3;

  localparam logic [1:0] REG_MEMORY_PAGES = 2'd0;
  localparam logic [1:0] REG_KERNEL_END   = 2'd1;
  localparam logic [1:0] REG_HEAP_PAGES   = 2'd2;

  localparam logic [CFG_W-1:0] MEMORY_PAGES_RST = 13'd4096;

  localparam logic [FLAG_W-1:0] FLAG_ALLOC  = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_KERNEL = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_HEAP   = 3'b100;
  localparam logic [FLAG_W-1:0] FLAG_ALL    = 3'b111;
  localparam logic [FLAG_W-1:0] FLAG_NONE   = 3'b000;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
    logic [FC_W-1:0]   free_count;
  } rsp_t;

  typedef struct packed {
    logic       init_start;
    logic       init_step;
    logic       init_finish;
    logic       ring_rd;
    logic       alloc_commit;
    logic       load_page;
    logic       free_commit;
    logic       emit;
    logic [1:0] status;
    logic       give_addr;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic range_err;
    logic alloc_bit;
    logic init_done;
  } stat_t;

endpackage

### rtl/core/pffla_ctrl.sv
// Controller FSM for the page-frame allocator: sequences init, alloc and free.
// Depends on pffla_pkg.
module pffla_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       op_i,
  input  pffla_pkg::stat_t stat_i,
  output pffla_pkg::cmd_t  cmd_o,
  output logic             busy_o
);
  import pffla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_RUN,
    S_ALLOC_WR,
    S_FREE_WR
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_INIT: begin
              cmd.init_start = 1'b1;
              state_d        = S_INIT_RUN;
            end
            OP_ALLOC: begin
              if (stat_i.empty) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_EMPTY;
              end else begin
                cmd.ring_rd = 1'b1;
                state_d     = S_ALLOC_WR;
              end
            end
            OP_FREE: begin
              if (stat_i.range_err) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_RANGE;
              end else begin
                cmd.load_page = 1'b1;
                state_d       = S_FREE_WR;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.status = STATUS_OK;
            end
          endcase
        end
      end
      S_INIT_RUN: begin
        if (stat_i.init_done) begin
          cmd.init_finish = 1'b1;
          cmd.emit        = 1'b1;
          cmd.status      = STATUS_OK;
          state_d         = S_IDLE;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_commit = 1'b1;
        cmd.emit         = 1'b1;
        cmd.status       = STATUS_OK;
        cmd.give_addr    = 1'b1;
        state_d          = S_IDLE;
      end
      S_FREE_WR: begin
        cmd.emit = 1'b1;
        if (stat_i.alloc_bit) begin
          cmd.free_commit = 1'b1;
          cmd.status      = STATUS_OK;
        end else begin
          cmd.status = STATUS_NOTALLOC;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/core/pffla_datapath.sv
// Datapath: config registers, free ring and flag memories, pointers, result register.
// Depends on pffla_pkg.
module pffla_datapath #(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [pffla_pkg::CFG_W-1:0] cfg_data_i,
  input  pffla_pkg::req_t             req_i,
  input  pffla_pkg::cmd_t             cmd_i,
  output pffla_pkg::stat_t            stat_o,
  output logic                        done_o,
  output pffla_pkg::rsp_t             rsp_o
);
  import pffla_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PAGES);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_PAGES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PAGES);

  logic [CFG_W-1:0]  mem_pages_q, kend_q, heap_q;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     total_q, total_d, idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d, limit_q, limit_d;
  logic [IW-1:0]     page_q;
  logic [IW-1:0]     ring_rd_q;
  logic [FLAG_W-1:0] flag_rd_q;
  logic              done_q;
  rsp_t              rsp_q;

  logic [IW-1:0]     ring_mem [MAX_PAGES];
  logic [FLAG_W-1:0] flag_mem [MAX_PAGES];

  logic [ADDR_W-1:0] addr_page;
  logic              range_err;
  logic [CW-1:0]     avail_pages;
  logic [31:0]       heap_end;
  logic [31:0]       idx_ext;
  logic              in_kernel, in_heap;
  logic              full;
  logic [IW-1:0]     head_nx, tail_nx;
  logic [63:0]       shifted;

  logic              flag_we;
  logic [IW-1:0]     flag_addr;
  logic [FLAG_W-1:0] flag_wdata, flag_mask;
  logic              ring_we;
  logic [IW-1:0]     ring_waddr, ring_wdata;

  assign addr_page   = req_i.free_address >> PAGE_SHIFT;
  assign range_err   = (addr_page >= 32'(limit_q)) || (addr_page >= 32'(MAX_PAGES));
  assign avail_pages = (32'(mem_pages_q) > 32'(MAX_PAGES)) ? FULL_CNT : CW'(mem_pages_q);
  assign heap_end    = 32'(kend_q) + 32'(heap_q);
  assign idx_ext     = 32'(idx_q);
  assign in_kernel   = idx_ext < 32'(kend_q);
  assign in_heap     = idx_ext < heap_end;
  assign full        = (total_q == FULL_CNT);
  assign head_nx     = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
  assign tail_nx     = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
  assign shifted     = 64'(ring_rd_q) << PAGE_SHIFT;

  always_comb begin
    flag_we    = 1'b0;
    flag_addr  = ring_rd_q;
    flag_wdata = FLAG_NONE;
    flag_mask  = FLAG_NONE;
    ring_we    = 1'b0;
    ring_waddr = tail_q;
    ring_wdata = page_q;
    head_d     = head_q;
    tail_d     = tail_q;
    total_d    = total_q;
    idx_d      = idx_q;
    count_d    = count_q;
    limit_d    = limit_q;
    if (cmd_i.init_start) begin
      head_d  = '0;
      tail_d  = '0;
      total_d = '0;
      idx_d   = '0;
      count_d = avail_pages;
    end
    if (cmd_i.init_step) begin
      flag_we   = 1'b1;
      flag_addr = idx_q[IW-1:0];
      flag_mask = FLAG_ALL;
      idx_d     = idx_q + 1'b1;
      if (in_kernel) begin
        flag_wdata = FLAG_ALLOC | FLAG_KERNEL;
      end else if (in_heap) begin
        flag_wdata = FLAG_ALLOC | FLAG_HEAP;
      end else begin
        flag_wdata = FLAG_NONE;
        if (!full) begin
          ring_we    = 1'b1;
          ring_wdata = idx_q[IW-1:0];
          tail_d     = tail_nx;
          total_d    = total_q + 1'b1;
        end
      end
    end
    if (cmd_i.init_finish) begin
      limit_d = count_q;
    end
    if (cmd_i.alloc_commit) begin
      flag_we    = 1'b1;
      flag_addr  = ring_rd_q;
      flag_mask  = FLAG_ALLOC | FLAG_KERNEL;
      flag_wdata = FLAG_ALLOC | FLAG_KERNEL;
      head_d     = head_nx;
      total_d    = total_q - 1'b1;
    end
    if (cmd_i.free_commit) begin
      flag_we    = 1'b1;
      flag_addr  = page_q;
      flag_mask  = FLAG_ALLOC;
      flag_wdata = FLAG_NONE;
      if (!full) begin
        ring_we = 1'b1;
        tail_d  = tail_nx;
        total_d = total_q + 1'b1;
      end
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (cmd_i.ring_rd) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      for (int b = 0; b < FLAG_W; b++) begin
        if (flag_mask[b]) begin
          flag_mem[flag_addr][b] <= flag_wdata[b];
        end
      end
    end
    if (cmd_i.load_page) begin
      flag_rd_q <= flag_mem[addr_page[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_pages_q <= MEMORY_PAGES_RST;
      kend_q      <= '0;
      heap_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      limit_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MEMORY_PAGES: mem_pages_q <= cfg_data_i;
          REG_KERNEL_END:   kend_q      <= cfg_data_i;
          REG_HEAP_PAGES:   heap_q      <= cfg_data_i;
          default:          ;
        endcase
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      limit_q <= limit_d;
      done_q  <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_page) begin
      page_q <= addr_page[IW-1:0];
    end
    if (cmd_i.emit) begin
      rsp_q.page_address <= cmd_i.give_addr ? shifted[ADDR_W-1:0] : '0;
      rsp_q.status       <= cmd_i.status;
      rsp_q.free_count   <= FC_W'(total_d);
    end
  end

  assign stat_o.empty     = (total_q == '0);
  assign stat_o.range_err = range_err;
  assign stat_o.alloc_bit = |(flag_rd_q & FLAG_ALLOC);
  assign stat_o.init_done = (idx_q == count_q);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### rtl/core/page_frame_free_list_allocator.sv
// Page-frame allocator top level: FIFO free list of physical pages; uses pffla_pkg,
// pffla_ctrl and pffla_datapath.
// Alloc and in-range free: registered ring or flag read, then write-back; busy is held, so
// no new request is taken until each is done. Empty alloc, out-of-range free, op 3: answered
// straight from idle. Init: one page per cycle. Results are one-cycle done_o strobes.
// Reset clears pointers and counts and restores config defaults; memories undefined until init.
module page_frame_free_list_allocator #(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pffla_pkg::req_t             req_i,
  output logic                        done_o,
  output pffla_pkg::rsp_t             rsp_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [pffla_pkg::CFG_W-1:0] cfg_data_i
);
  import pffla_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy_int;

  pffla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  pffla_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  assign busy = busy_int;

endmodule

### rtl/core/pffla_checker.sv
// Port-level checker for the page-frame allocator, bound to the top level.
// Depends on pffla_pkg and page_frame_free_list_allocator_assert.svh.
`include "page_frame_free_list_allocator_assert.svh"

module pffla_checker #(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input pffla_pkg::rsp_t rsp_o
);
  import pffla_pkg::*;

  `PFFLA_ASSERT_IMP(a_addr_only_ok, done_o && rsp_o.page_address != '0, rsp_o.status == STATUS_OK)
  `PFFLA_ASSERT_IMP(a_addr_aligned, done_o, (rsp_o.page_address & ((32'd1 << PAGE_SHIFT) - 32'd1)) == '0)
  `PFFLA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_o)
  `PFFLA_ASSERT_IMP(a_busy_ends_done, $fell(busy), done_o)

endmodule

bind page_frame_free_list_allocator pffla_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_pffla_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
